// File: rtl/wmrq_pkg.sv
// shared types and constants for the wildcard match receive queue
package wmrq_pkg;

    localparam int OCC_W = 5;

    typedef enum logic {
        MODE_PUSH    = 1'b0,
        MODE_CONSUME = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_PUSHED   = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_MATCHED  = 2'd2,
        ST_NO_MATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] addr;
        logic        addr_any;
        logic [15:0] port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  flags;
        logic [15:0] payload_ref;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic [31:0]      match_addr;
        logic [15:0]      match_port;
        logic [31:0]      match_seq;
        logic [31:0]      match_ack;
        logic [7:0]       match_flags;
        logic [15:0]      match_ref;
        logic [OCC_W-1:0] occupancy;
    } t_out;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  flags;
        logic [15:0] payload_ref;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: rtl/wmrq_ram.sv
// generic single write, single read ram with registered read data
module wmrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/wmrq_match.sv
// shared wildcard compare unit for one stored header against the filter
module wmrq_match (
    input  wmrq_pkg::t_entry i_entry,
    input  wmrq_pkg::t_in    i_filter,
    output logic             o_hit
);

    logic addr_ok;
    logic port_ok;
    logic seq_ok;
    logic ack_ok;
    logic flags_ok;

    assign addr_ok  = i_filter.addr_any || (i_entry.addr == i_filter.addr);
    assign port_ok  = (i_filter.port == '0) || (i_entry.port == i_filter.port);
    assign seq_ok   = (i_filter.seq_num == '0) || (i_entry.seq_num == i_filter.seq_num);
    assign ack_ok   = (i_filter.ack_num == '0) || (i_entry.ack_num == i_filter.ack_num);
    assign flags_ok = (i_filter.flags == '0) || (i_entry.flags == i_filter.flags);

    assign o_hit = addr_ok && port_ok && seq_ok && ack_ok && flags_ok;

endmodule

// File: rtl/wildcard_match_receive_queue_top.sv
// top level of the wildcard match receive queue with its sequencer
//
// input channel: i_in_valid / o_in_stall carry one t_in per transfer.
// mode push appends a header at the tail, or drops it when the queue holds
// QUEUE_DEPTH entries. mode consume scans from the oldest entry for the first
// one that matches all filters, removes it and moves later entries down.
// output channel: o_out_valid / i_out_stall carry exactly one t_out per input.
// the headers live in one ram with one read and one write port; a single
// compare unit checks one entry at a time, reading it in S_SCAN_RD and
// comparing it in S_SCAN_CMP, and closing the gap copies one entry at a time
// through the same ram ports, reading in S_SHIFT_RD and writing in S_SHIFT_WR.
// a push passes S_PUSH and then S_FINISH; a consume scans the held entries,
// closes the gap after a match, then passes S_FINISH.
// only one item is handled at a time: o_in_stall stays high until the result
// is loaded into the output register; the next item may be taken while the
// previous result still waits in that register.
// a stalled result holds the block in its final step until the output frees.
// reset empties the queue; stored headers are not cleared.
module wildcard_match_receive_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  wmrq_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output wmrq_pkg::t_out   o_out_data
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    wmrq_pkg::t_state r_state, n_state;
    wmrq_pkg::t_in    r_item, n_item;
    wmrq_pkg::t_out   r_res, n_res;
    wmrq_pkg::t_out   r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;

    logic             ram_wr_en;
    logic [IW-1:0]    ram_wr_addr;
    wmrq_pkg::t_entry ram_wr_data;
    logic             ram_rd_en;
    logic [IW-1:0]    ram_rd_addr;
    wmrq_pkg::t_entry ram_rd_data;
    logic [CW-1:0]    idx_inc;
    logic             hit;

    wmrq_ram #(
        .WIDTH (wmrq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    wmrq_match u_match (
        .i_entry  (ram_rd_data),
        .i_filter (r_item),
        .o_hit    (hit)
    );

    assign idx_inc = r_idx + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmrq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
        r_idx  <= n_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_idx       = r_idx;
        n_count     = r_count;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx[IW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx[IW-1:0];
        case (r_state)
            wmrq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_res  = '0;
                    n_idx  = '0;
                    if (i_in_data.mode == wmrq_pkg::MODE_CONSUME) begin
                        n_state = wmrq_pkg::S_SCAN_RD;
                    end else begin
                        n_state = wmrq_pkg::S_PUSH;
                    end
                end
            end
            wmrq_pkg::S_PUSH: begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_res.status = wmrq_pkg::ST_DROPPED;
                end else begin
                    ram_wr_en               = 1'b1;
                    ram_wr_addr             = r_count[IW-1:0];
                    ram_wr_data.addr        = r_item.addr;
                    ram_wr_data.port        = r_item.port;
                    ram_wr_data.seq_num     = r_item.seq_num;
                    ram_wr_data.ack_num     = r_item.ack_num;
                    ram_wr_data.flags       = r_item.flags;
                    ram_wr_data.payload_ref = r_item.payload_ref;
                    n_count                 = r_count + CW'(1);
                    n_res.status            = wmrq_pkg::ST_PUSHED;
                end
                n_state = wmrq_pkg::S_FINISH;
            end
            wmrq_pkg::S_SCAN_RD: begin
                if (r_idx < r_count) begin
                    ram_rd_en = 1'b1;
                    n_state   = wmrq_pkg::S_SCAN_CMP;
                end else begin
                    n_res.status = wmrq_pkg::ST_NO_MATCH;
                    n_state      = wmrq_pkg::S_FINISH;
                end
            end
            wmrq_pkg::S_SCAN_CMP: begin
                if (hit) begin
                    n_res.status      = wmrq_pkg::ST_MATCHED;
                    n_res.match_addr  = ram_rd_data.addr;
                    n_res.match_port  = ram_rd_data.port;
                    n_res.match_seq   = ram_rd_data.seq_num;
                    n_res.match_ack   = ram_rd_data.ack_num;
                    n_res.match_flags = ram_rd_data.flags;
                    n_res.match_ref   = ram_rd_data.payload_ref;
                    n_state           = wmrq_pkg::S_SHIFT_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = wmrq_pkg::S_SCAN_RD;
                end
            end
            wmrq_pkg::S_SHIFT_RD: begin
                if (idx_inc < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_inc[IW-1:0];
                    n_state     = wmrq_pkg::S_SHIFT_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = wmrq_pkg::S_FINISH;
                end
            end
            wmrq_pkg::S_SHIFT_WR: begin
                ram_wr_en = 1'b1;
                n_idx     = idx_inc;
                n_state   = wmrq_pkg::S_SHIFT_RD;
            end
            wmrq_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out           = r_res;
                    n_out.occupancy = wmrq_pkg::OCC_W'(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = wmrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wmrq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != wmrq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous item still busy");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wmrq_pkg::S_SHIFT_WR) |-> (idx_inc < r_count))
        else $error("compaction copy beyond valid entries");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == wmrq_pkg::S_PUSH || $past(r_state) == wmrq_pkg::S_SHIFT_RD))
        else $error("entry count changed outside push or removal");

endmodule
